FILE: rtl/core/owtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtp_pkg: shared types and constants of the one-wire temperature poller
// Bus timing in microsecond ticks, bus phases, register codes and the
// payload structs passed between the poller's modules.
// ----------------------------------------------------------------------------
package owtp_pkg;

    // Widths of the timing counter and the data paths.
    localparam int TIMER_W   = 20;
    localparam int CODE_W    = 8;
    localparam int READING_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // Default number of bits clocked in from the scratchpad.
    localparam int READ_BITS_DEFAULT = 16;

    // Bus timing, all in one-microsecond ticks.
    localparam logic [TIMER_W-1:0] RESET_LOW_TICKS      = TIMER_W'(480);
    localparam logic [TIMER_W-1:0] RESET_REL_TICKS      = TIMER_W'(480);
    localparam logic [TIMER_W-1:0] PRESENCE_SAMPLE_TICK = TIMER_W'(70);
    localparam logic [TIMER_W-1:0] WRITE_ONE_LOW        = TIMER_W'(10);
    localparam logic [TIMER_W-1:0] WRITE_ZERO_LOW       = TIMER_W'(55);
    localparam logic [TIMER_W-1:0] WRITE_SLOT_TICKS     = TIMER_W'(62);
    localparam logic [TIMER_W-1:0] READ_LOW_TICKS       = TIMER_W'(2);
    localparam logic [TIMER_W-1:0] READ_SAMPLE_TICK     = TIMER_W'(12);
    localparam logic [TIMER_W-1:0] READ_SLOT_TICKS      = TIMER_W'(64);
    localparam int                 BYTE_BITS            = 8;

    // Register reset values.
    localparam logic [TIMER_W-1:0] DEFAULT_WAIT_TICKS = TIMER_W'(750 * 1000);
    localparam logic [CODE_W-1:0]  DEFAULT_SKIP_ROM   = 8'hCC;
    localparam logic [CODE_W-1:0]  DEFAULT_CONVERT    = 8'h44;
    localparam logic [CODE_W-1:0]  DEFAULT_READ_SP    = 8'hBE;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONV_WAIT = 2'd0,
        CFG_SKIP_ROM  = 2'd1,
        CFG_CONVERT   = 2'd2,
        CFG_READ_SP   = 2'd3
    } cfg_idx_t;

    // Bus sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST1_LOW,
        PH_RST1_REL,
        PH_WR_SKIP1,
        PH_WR_CONV,
        PH_CONV_WAIT,
        PH_RST2_LOW,
        PH_RST2_REL,
        PH_WR_SKIP2,
        PH_WR_READ,
        PH_READ
    } phase_t;

    // Current register contents.
    typedef struct packed {
        logic [TIMER_W-1:0] conv_wait;
        logic [CODE_W-1:0]  skip_rom;
        logic [CODE_W-1:0]  convert;
        logic [CODE_W-1:0]  read_sp;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic                        pull_low;
        logic signed [READING_W-1:0] temperature;
        logic                        done;
        logic                        missing;
        logic                        busy;
    } result_t;

endpackage : owtp_pkg
`default_nettype wire

FILE: rtl/core/owtp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtp_cfg_regs: configuration registers
// Holds the conversion wait and the three command bytes, written through
// a valid/ready port that is always ready.
// ----------------------------------------------------------------------------
module owtp_cfg_regs
    import owtp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index of a write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CONV_WAIT: cfg_next.conv_wait = cfg_data[TIMER_W-1:0];
                CFG_SKIP_ROM:  cfg_next.skip_rom  = cfg_data[CODE_W-1:0];
                CFG_CONVERT:   cfg_next.convert   = cfg_data[CODE_W-1:0];
                CFG_READ_SP:   cfg_next.read_sp   = cfg_data[CODE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conv_wait <= DEFAULT_WAIT_TICKS;
            cfg_reg.skip_rom  <= DEFAULT_SKIP_ROM;
            cfg_reg.convert   <= DEFAULT_CONVERT;
            cfg_reg.read_sp   <= DEFAULT_READ_SP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : owtp_cfg_regs
`default_nettype wire

FILE: rtl/core/owtp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtp_step: one-wire bus sequencer
// Advances the bus state by one microsecond tick per accepted item and
// forms that tick's result in the same cycle.
// ----------------------------------------------------------------------------
module owtp_step
    import owtp_pkg::*;
#(
    parameter int READ_BITS = READ_BITS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire logic start_req,
    input  wire logic bus_level,
    input  cfg_t      cfg,
    output result_t   result
);

    localparam int BC_W = $clog2(READ_BITS + 1);

    phase_t                 phase_reg, phase_next, phase_eff;
    logic [TIMER_W-1:0]     timer_reg, timer_next, timer_eff, timer_inc;
    logic [BC_W-1:0]        bit_count_reg, bit_count_next, bit_count_inc;
    logic [READING_W-1:0]   shift_reg, shift_next, shift_sampled;
    logic [READING_W-1:0]   stored_reg, stored_next;
    logic                   presence_reg, presence_next, presence_cur;
    logic                   pull_low, done, missing;

    // Phase and timer after a start request or the end of the conversion wait.
    always_comb
    begin
        phase_eff = phase_reg;
        timer_eff = timer_reg;
        if (phase_reg == PH_IDLE && start_req)
        begin
            phase_eff = PH_RST1_LOW;
            timer_eff = '0;
        end
        if (phase_reg == PH_CONV_WAIT && timer_reg >= cfg.conv_wait)
        begin
            phase_eff = PH_RST2_LOW;
            timer_eff = '0;
        end
    end

    // Helpers shared by the next-state and output logic.
    always_comb
    begin
        timer_inc     = timer_eff + TIMER_W'(1);
        bit_count_inc = bit_count_reg + BC_W'(1);
        presence_cur  = (timer_eff == PRESENCE_SAMPLE_TICK) ? !bus_level : presence_reg;
        shift_sampled = shift_reg;
        if (timer_eff == READ_SAMPLE_TICK && bus_level
            && bit_count_reg < BC_W'(READING_W))
        begin
            shift_sampled[bit_count_reg[$clog2(READING_W)-1:0]] = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next     = phase_eff;
        timer_next     = timer_eff;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        stored_next    = stored_reg;
        presence_next  = presence_reg;
        case (phase_eff)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_RST1_LOW, PH_RST2_LOW:
            begin
                timer_next = timer_inc;
                if (timer_inc >= RESET_LOW_TICKS)
                begin
                    phase_next    = (phase_eff == PH_RST1_LOW) ? PH_RST1_REL : PH_RST2_REL;
                    timer_next    = '0;
                    presence_next = 1'b0;
                end
            end
            PH_RST1_REL, PH_RST2_REL:
            begin
                presence_next = presence_cur;
                timer_next    = timer_inc;
                if (timer_inc >= RESET_REL_TICKS)
                begin
                    timer_next     = '0;
                    bit_count_next = '0;
                    if (!presence_cur)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = (phase_eff == PH_RST1_REL) ? PH_WR_SKIP1 : PH_WR_SKIP2;
                        shift_next = READING_W'(cfg.skip_rom);
                    end
                end
            end
            PH_WR_SKIP1, PH_WR_CONV, PH_WR_SKIP2, PH_WR_READ:
            begin
                timer_next = timer_inc;
                if (timer_inc >= WRITE_SLOT_TICKS)
                begin
                    timer_next     = '0;
                    shift_next     = shift_reg >> 1;
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc >= BC_W'(BYTE_BITS))
                    begin
                        bit_count_next = '0;
                        case (phase_eff)
                            PH_WR_SKIP1:
                            begin
                                phase_next = PH_WR_CONV;
                                shift_next = READING_W'(cfg.convert);
                            end
                            PH_WR_CONV:
                            begin
                                phase_next = PH_CONV_WAIT;
                            end
                            PH_WR_SKIP2:
                            begin
                                phase_next = PH_WR_READ;
                                shift_next = READING_W'(cfg.read_sp);
                            end
                            default:
                            begin
                                phase_next = PH_READ;
                                shift_next = '0;
                            end
                        endcase
                    end
                end
            end
            PH_CONV_WAIT:
            begin
                timer_next = timer_inc;
            end
            PH_READ:
            begin
                shift_next = shift_sampled;
                timer_next = timer_inc;
                if (timer_inc >= READ_SLOT_TICKS)
                begin
                    timer_next     = '0;
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc >= BC_W'(READ_BITS))
                    begin
                        stored_next    = shift_sampled;
                        phase_next     = PH_IDLE;
                        bit_count_next = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Outputs of this tick.
    always_comb
    begin
        pull_low = 1'b0;
        done     = 1'b0;
        missing  = 1'b0;
        case (phase_eff)
            PH_RST1_LOW, PH_RST2_LOW:
            begin
                pull_low = 1'b1;
            end
            PH_RST1_REL, PH_RST2_REL:
            begin
                missing = (timer_inc >= RESET_REL_TICKS) && !presence_cur;
            end
            PH_WR_SKIP1, PH_WR_CONV, PH_WR_SKIP2, PH_WR_READ:
            begin
                pull_low = timer_eff < (shift_reg[0] ? WRITE_ONE_LOW : WRITE_ZERO_LOW);
            end
            PH_READ:
            begin
                pull_low = timer_eff < READ_LOW_TICKS;
                done     = (timer_inc >= READ_SLOT_TICKS)
                           && (bit_count_inc >= BC_W'(READ_BITS));
            end
            default:
            begin
                pull_low = 1'b0;
            end
        endcase
    end

    assign result.pull_low    = pull_low;
    assign result.temperature = $signed(stored_next);
    assign result.done        = done;
    assign result.missing     = missing;
    assign result.busy        = (phase_eff != PH_IDLE);

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            stored_reg    <= '0;
            presence_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            stored_reg    <= stored_next;
            presence_reg  <= presence_next;
        end
    end

endmodule : owtp_step
`default_nettype wire

FILE: rtl/core/owtp_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtp_out_buf: result register with skid stage
// Holds result items for the output channel so that a new item can be
// taken while an earlier result still waits.
// ----------------------------------------------------------------------------
module owtp_out_buf
    import owtp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  result_t   push_data,
    output logic      can_push,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !main_valid_reg)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the two stages.
    always_ff @(posedge clk)
    begin
        if (out_ready || !main_valid_reg)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule : owtp_out_buf
`default_nettype wire

FILE: rtl/core/one_wire_temperature_poller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_temperature_poller: one-wire bus master polling one temperature
// sensor, one input item per microsecond tick of bus time.
// Output: the result of an item is formed combinationally and registered
//   in the output register, or in the skid stage while the output stalls.
// Throughput: one item per cycle while the skid stage is empty; the output
//   skid stage keeps input ready while one result waits.
// Reset: asynchronous, active low; the sequencer goes idle, the reading
//   clears and the registers take their default values.
// ----------------------------------------------------------------------------
module one_wire_temperature_poller
    import owtp_pkg::*;
#(
    parameter int READ_BITS = READ_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Tick items.
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  start_req,
    input  wire logic                  bus_level,
    // Result items.
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       bus_pull_low,
    output logic signed [READING_W-1:0] temperature_raw,
    output logic                       reading_done,
    output logic                       sensor_missing,
    output logic                       busy_res
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_data;
    logic    can_push;
    logic    accept;

    assign in_ready = can_push;
    assign accept   = in_valid && can_push;

    // Configuration registers.
    owtp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Bus sequencer.
    owtp_step #(
        .READ_BITS (READ_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .start_req (start_req),
        .bus_level (bus_level),
        .cfg       (cfg),
        .result    (step_result)
    );

    // Result register and skid stage.
    owtp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign bus_pull_low    = out_data.pull_low;
    assign temperature_raw = out_data.temperature;
    assign reading_done    = out_data.done;
    assign sensor_missing  = out_data.missing;
    assign busy_res        = out_data.busy;

endmodule : one_wire_temperature_poller
`default_nettype wire

FILE: rtl/core/owtp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtp_checker: port-level checks of the one-wire temperature poller
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module owtp_checker
    import owtp_pkg::*;
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         bus_pull_low,
    input wire logic signed [READING_W-1:0]  temperature_raw,
    input wire logic                         reading_done,
    input wire logic                         sensor_missing,
    input wire logic                         busy_res
);

    // A cycle ends either with a reading or with a missing sensor, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reading_done && sensor_missing))
        else $error("reading_done and sensor_missing in one item");

    // A stored reading ends a running cycle with the line released.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reading_done) |-> (busy_res && !bus_pull_low))
        else $error("reading_done outside a cycle or with line pulled low");

    // A missing sensor is reported at the end of a released reset window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sensor_missing) |-> (busy_res && !bus_pull_low))
        else $error("sensor_missing outside a released reset window");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(temperature_raw)))
        else $error("stalled result item changed");

endmodule : owtp_checker

bind one_wire_temperature_poller owtp_checker u_owtp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .bus_pull_low    (bus_pull_low),
    .temperature_raw (temperature_raw),
    .reading_done    (reading_done),
    .sensor_missing  (sensor_missing),
    .busy_res        (busy_res)
);
`default_nettype wire
